// ===== design/wbrc_pkg.sv =====
// shared types and constants for the window blind relay controller
`default_nettype none

package wbrc_pkg;

	// command codes of an input request
	typedef enum logic [3:0] {
		OP_TICK      = 4'd0,
		OP_UP        = 4'd1,
		OP_UP_TIMED  = 4'd2,
		OP_DOWN      = 4'd3,
		OP_DOWN_TIMED = 4'd4,
		OP_TOGGLE_UP = 4'd5,
		OP_TOGGLE_DN = 4'd6,
		OP_SUN       = 4'd7,
		OP_STOP      = 4'd8
	} op_t;

	// drive state of one channel
	typedef enum logic [1:0] {
		DS_STOP = 2'd0,
		DS_UP   = 2'd1,
		DS_DOWN = 2'd2
	} drive_t;

	// believed blind position
	typedef enum logic [1:0] {
		POS_UNDEF  = 2'd0,
		POS_OPEN   = 2'd1,
		POS_CLOSED = 2'd2
	} pos_t;

	// configuration register indexes
	localparam logic [1:0] CFG_FULL_TRAVEL  = 2'd0;
	localparam logic [1:0] CFG_SUN_GAP      = 2'd1;
	localparam logic [1:0] CFG_STAGGER_STEP = 2'd2;

	// configuration reset values
	localparam logic [23:0] FULL_TRAVEL_RST  = 24'd60000;
	localparam logic [23:0] SUN_GAP_RST      = 24'd2000;
	localparam logic [15:0] STAGGER_STEP_RST = 16'd800;

	// field widths
	localparam int unsigned TICKS_W = 24;
	localparam int unsigned CNT_W   = 25;
	localparam int unsigned STEP_W  = 16;

	// configuration seen by every channel
	typedef struct packed {
		logic [TICKS_W-1:0] full_travel;
		logic [TICKS_W-1:0] sun_gap;
		logic [STEP_W-1:0]  stagger_step;
	} cfg_t;

	// command broadcast to every channel
	typedef struct packed {
		op_t                op;
		logic [TICKS_W-1:0] run_time;
	} cmd_t;

	// channel state after a request
	typedef struct packed {
		drive_t drive;
		pos_t   pos;
	} status_t;

endpackage

`default_nettype wire

// ===== design/wbrc_cell.sv =====
// one blind channel: state registers and single-pass next-state logic
`default_nettype none

module wbrc_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             sel,
	input  wire wbrc_pkg::cmd_t   cmd,
	input  wire wbrc_pkg::cfg_t   cfg,
	input  wire logic [1:0]       stagger_in,
	output logic [1:0]            stagger_out,
	output wbrc_pkg::status_t     status_nxt
);
	import wbrc_pkg::*;

	drive_t           drive_q, drive_d;
	pos_t             pos_q, pos_d, pos_x;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_x, cnt_dec;
	logic             end_q, end_d;
	logic             sun_q, sun_d;

	logic [1:0]       stg_inc;
	logic [17:0]      step_mul;
	logic [CNT_W-1:0] dflt_len;

	logic             adv, req, sun_go, halt, launch, launch_sun;
	drive_t           req_dir, launch_dir;
	pos_t             req_target;
	logic [CNT_W-1:0] req_len, launch_len;

	// default run length with the next stagger count
	always_comb begin
		stg_inc  = stagger_in + 2'd1;
		step_mul = 18'(stg_inc) * 18'(cfg.stagger_step);
		dflt_len = CNT_W'(cfg.full_travel) + CNT_W'(step_mul);
		cnt_dec  = (cnt_q != '0) ? cnt_q - CNT_W'(1) : '0;
	end

	// command and tick decode
	always_comb begin
		adv     = 1'b0;
		req     = 1'b0;
		req_dir = DS_UP;
		req_len = dflt_len;
		sun_go  = 1'b0;
		halt    = 1'b0;
		pos_x   = pos_q;
		cnt_x   = cnt_q;
		if (cmd.op == OP_TICK) begin
			if (drive_q != DS_STOP) begin
				if (cnt_dec != '0) begin
					cnt_x = cnt_dec;
				end else begin
					// run expired
					if (end_q) begin
						pos_x = (drive_q == DS_UP) ? POS_OPEN : POS_CLOSED;
					end
					if (sun_q) begin
						sun_go = 1'b1;
					end else begin
						halt = 1'b1;
					end
				end
			end
		end else if (sel) begin
			unique case (cmd.op)
				OP_UP: begin
					adv = 1'b1; req = 1'b1; req_dir = DS_UP; req_len = dflt_len;
				end
				OP_UP_TIMED: begin
					req = 1'b1; req_dir = DS_UP; req_len = CNT_W'(cmd.run_time);
				end
				OP_DOWN: begin
					adv = 1'b1; req = 1'b1; req_dir = DS_DOWN; req_len = dflt_len;
				end
				OP_DOWN_TIMED: begin
					req = 1'b1; req_dir = DS_DOWN; req_len = CNT_W'(cmd.run_time);
				end
				OP_TOGGLE_UP: begin
					if (drive_q == DS_STOP) begin
						adv = 1'b1; req = 1'b1; req_dir = DS_UP; req_len = dflt_len;
					end else begin
						halt = 1'b1;
					end
				end
				OP_TOGGLE_DN: begin
					if (drive_q == DS_STOP) begin
						adv = 1'b1; req = 1'b1; req_dir = DS_DOWN; req_len = dflt_len;
					end else begin
						halt = 1'b1;
					end
				end
				OP_SUN:  sun_go = 1'b1;
				OP_STOP: halt = 1'b1;
				default: ;
			endcase
		end
	end

	// drive request and sun sequence resolve into halt and launch
	always_comb begin
		launch     = 1'b0;
		launch_dir = DS_DOWN;
		launch_len = dflt_len;
		launch_sun = 1'b0;
		req_target = (req_dir == DS_UP) ? POS_OPEN : POS_CLOSED;
		if (req && (drive_q != req_dir)) begin
			// opposite drive stops first, stopped channel is already clear
			if (pos_q != req_target) begin
				launch     = 1'b1;
				launch_dir = req_dir;
				launch_len = req_len;
			end
		end
		if (sun_go) begin
			launch = 1'b1;
			if (pos_x == POS_CLOSED) begin
				launch_dir = DS_UP;
				launch_len = CNT_W'(cfg.sun_gap);
			end else begin
				launch_dir = DS_DOWN;
				launch_len = dflt_len;
				launch_sun = 1'b1;
			end
		end
	end

	// next channel state
	always_comb begin
		drive_d = drive_q;
		pos_d   = pos_x;
		cnt_d   = cnt_x;
		end_d   = end_q;
		sun_d   = sun_q;
		if (halt || (req && (drive_q != req_dir))) begin
			drive_d = DS_STOP;
			cnt_d   = '0;
			end_d   = 1'b0;
			sun_d   = 1'b0;
		end
		if (launch) begin
			pos_d   = POS_UNDEF;
			drive_d = launch_dir;
			cnt_d   = launch_len;
			end_d   = (launch_len >= CNT_W'(cfg.full_travel));
			sun_d   = launch_sun;
		end
		stagger_out = (adv || (sun_go && launch_sun)) ? stg_inc : stagger_in;
		status_nxt.drive = drive_d;
		status_nxt.pos   = pos_d;
	end

	// channel state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= DS_STOP;
			pos_q   <= POS_UNDEF;
			cnt_q   <= '0;
			end_q   <= 1'b0;
			sun_q   <= 1'b0;
		end else if (en) begin
			drive_q <= drive_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			end_q   <= end_d;
			sun_q   <= sun_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/window_blind_relay_controller_unit.sv =====
// top level of the window blind relay controller
`default_nettype none

// Drives NUM_BLINDS blind motors through two relays each (bit 2n down, bit 2n+1
// up). Each request on the s_ stream (a tick or a channel command) yields exactly
// one result on the m_ stream: relay bits, drive states and positions after the
// request, for the first four channels. One request is taken every clock cycle
// while the result side does not stall; a result is presented after the input
// register takes the request and the result register takes the update, computed
// by the single-pass update of all channels between them. The input side keeps
// accepting while a result waits, as long as the input register is empty or its
// request moves on into the result register. Configuration writes take effect
// for the requests processed after them and are accepted in every cycle.
module window_blind_relay_controller_unit #(
	parameter int unsigned NUM_BLINDS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // op [3:0], channel [5:4], run_time [29:6]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // relay_outputs [7:0], drive_states [15:8],
	                                    // positions [23:16]
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	import wbrc_pkg::*;

	localparam int unsigned OUT_CH = (NUM_BLINDS < 4) ? NUM_BLINDS : 4;

	logic               valid_s1;
	op_t                op_s1;
	logic [1:0]         channel_s1;
	logic [TICKS_W-1:0] run_time_s1;
	logic               valid_s2;
	logic [23:0]        result_s2;
	logic               adv;

	cfg_t               cfg_q;
	cmd_t               cmd;
	logic [1:0]         stagger_q;
	logic [1:0]         stg_chain [NUM_BLINDS+1];
	status_t            sts [NUM_BLINDS];
	logic [NUM_BLINDS-1:0] sel;
	logic [23:0]        result_d;

	// handshake: the channels update when a request moves into the result register
	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = result_s2;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_travel  <= FULL_TRAVEL_RST;
			cfg_q.sun_gap      <= SUN_GAP_RST;
			cfg_q.stagger_step <= STAGGER_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FULL_TRAVEL:  cfg_q.full_travel  <= cfg_data;
				CFG_SUN_GAP:      cfg_q.sun_gap      <= cfg_data;
				CFG_STAGGER_STEP: cfg_q.stagger_step <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1       <= op_t'(s_tdata[3:0]);
			channel_s1  <= s_tdata[5:4];
			run_time_s1 <= s_tdata[29:6];
		end
	end

	assign cmd.op       = op_s1;
	assign cmd.run_time = run_time_s1;
	assign stg_chain[0] = stagger_q;

	// channel cells, stagger count passes through them in channel order
	for (genvar ch = 0; ch < NUM_BLINDS; ch++) begin : g_ch
		assign sel[ch] = (32'(channel_s1) == ch);

		wbrc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv),
			.sel         (sel[ch]),
			.cmd         (cmd),
			.cfg         (cfg_q),
			.stagger_in  (stg_chain[ch]),
			.stagger_out (stg_chain[ch+1]),
			.status_nxt  (sts[ch])
		);
	end

	// stagger count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stagger_q <= 2'd0;
		end else if (adv) begin
			stagger_q <= stg_chain[NUM_BLINDS];
		end
	end

	// pack relay bits, drive states and positions
	always_comb begin
		result_d = '0;
		for (int k = 0; k < OUT_CH; k++) begin
			result_d[2*k]        = (sts[k].drive == DS_DOWN);
			result_d[2*k+1]      = (sts[k].drive == DS_UP);
			result_d[8+2*k +: 2] = sts[k].drive;
			result_d[16+2*k +: 2] = sts[k].pos;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result_d;
		end
	end

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are stalled");

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("processed request left no result");

	a_stagger_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(stagger_q))
		else $error("stagger count moved without a request");

	a_relay_pair_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2[0] && result_s2[1]))
		else $error("channel 0 up and down relays both on");
`endif

endmodule

`default_nettype wire

// ===== tb/wbrc_checker.sv =====
// request/result checker with a behavioral copy of the blind relay controller
`timescale 1ns / 1ps

module wbrc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,   // op [3:0], channel [5:4], run_time [29:6]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,   // relay_outputs [7:0], drive_states [15:8],
	                                    // positions [23:16]
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	import wbrc_pkg::*;

	localparam int CHANNELS = 4;
	localparam int REPORT_MAX = 10;

	// one result, packed in the same bit order as m_tdata
	typedef struct packed {
		logic [7:0] positions;
		logic [7:0] drives;
		logic [7:0] relays;
	} blind_status_t;

	// shadow configuration
	logic [TICKS_W-1:0] full_ticks;
	logic [TICKS_W-1:0] gap_ticks;
	logic [STEP_W-1:0]  step_ticks;

	// shadow channel state
	drive_t            drv[CHANNELS];
	pos_t              pos[CHANNELS];
	logic [CNT_W-1:0]  cnt[CHANNELS];
	logic              reach[CHANNELS];
	logic              sun_run[CHANNELS];
	logic [1:0]        stagger;

	blind_status_t expected_status[$];
	int            report_count;

	// default run length, advances the stagger first
	function automatic logic [CNT_W-1:0] next_default_len();
		stagger = stagger + 2'd1;
		return {1'b0, full_ticks} + CNT_W'(stagger) * CNT_W'(step_ticks);
	endfunction

	function automatic void halt_blind(int n);
		drv[n]     = DS_STOP;
		cnt[n]     = '0;
		reach[n]   = 1'b0;
		sun_run[n] = 1'b0;
	endfunction

	function automatic void start_run(int n, drive_t dir, logic [CNT_W-1:0] len,
			logic is_sun);
		pos[n]     = POS_UNDEF;
		drv[n]     = dir;
		cnt[n]     = len;
		reach[n]   = (len >= {1'b0, full_ticks});
		sun_run[n] = is_sun;
	endfunction

	// same direction ignored, opposite stopped, target end left stopped
	function automatic void request_drive(int n, drive_t dir, logic [CNT_W-1:0] len);
		drive_t other;
		pos_t   target;
		if (dir == DS_UP) begin
			other  = DS_DOWN;
			target = POS_OPEN;
		end else begin
			other  = DS_UP;
			target = POS_CLOSED;
		end
		if (drv[n] == dir)
			return;
		if (drv[n] == other)
			halt_blind(n);
		if (pos[n] == target)
			return;
		start_run(n, dir, len, 1'b0);
	endfunction

	// closed blind opens the gap, anything else closes as a sun run
	function automatic void sun_command(int n);
		if (drv[n] != DS_STOP)
			halt_blind(n);
		if (pos[n] == POS_CLOSED)
			start_run(n, DS_UP, {1'b0, gap_ticks}, 1'b0);
		else
			start_run(n, DS_DOWN, next_default_len(), 1'b1);
	endfunction

	// countdown and expiry in channel order
	function automatic void tick_all();
		for (int n = 0; n < CHANNELS; n++) begin
			if (drv[n] == DS_STOP)
				continue;
			if (cnt[n] != '0)
				cnt[n] = cnt[n] - 1'b1;
			if (cnt[n] != '0)
				continue;
			if (reach[n]) begin
				if (drv[n] == DS_UP)
					pos[n] = POS_OPEN;
				else
					pos[n] = POS_CLOSED;
			end
			if (sun_run[n])
				sun_command(n);
			else
				halt_blind(n);
		end
	endfunction

	// apply one request and return the state seen after it
	function automatic blind_status_t advance_blinds(logic [3:0] op, logic [1:0] ch,
			logic [TICKS_W-1:0] run_time);
		blind_status_t st;
		int n;
		n = ch;
		case (op)
			OP_TICK:       tick_all();
			OP_UP:         request_drive(n, DS_UP, next_default_len());
			OP_UP_TIMED:   request_drive(n, DS_UP, {1'b0, run_time});
			OP_DOWN:       request_drive(n, DS_DOWN, next_default_len());
			OP_DOWN_TIMED: request_drive(n, DS_DOWN, {1'b0, run_time});
			OP_TOGGLE_UP: begin
				if (drv[n] == DS_STOP)
					request_drive(n, DS_UP, next_default_len());
				else
					halt_blind(n);
			end
			OP_TOGGLE_DN: begin
				if (drv[n] == DS_STOP)
					request_drive(n, DS_DOWN, next_default_len());
				else
					halt_blind(n);
			end
			OP_SUN:        sun_command(n);
			OP_STOP:       halt_blind(n);
			default: ;
		endcase
		st = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			if (drv[k] == DS_DOWN)
				st.relays[2*k] = 1'b1;
			else if (drv[k] == DS_UP)
				st.relays[2*k+1] = 1'b1;
			st.drives[2*k +: 2]    = drv[k];
			st.positions[2*k +: 2] = pos[k];
		end
		return st;
	endfunction

	// watch the four channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		blind_status_t got;
		blind_status_t want;
		if (!arst_n) begin
			full_ticks = FULL_TRAVEL_RST;
			gap_ticks  = SUN_GAP_RST;
			step_ticks = STAGGER_STEP_RST;
			for (int n = 0; n < CHANNELS; n++) begin
				halt_blind(n);
				pos[n] = POS_UNDEF;
			end
			stagger = 2'd0;
			expected_status.delete();
			fail_count   = 0;
			report_count = 0;
			pending      = 0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FULL_TRAVEL:  full_ticks = cfg_data;
					CFG_SUN_GAP:      gap_ticks  = cfg_data;
					CFG_STAGGER_STEP: step_ticks = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			// accepted request
			if (s_tvalid && s_tready)
				expected_status.push_back(advance_blinds(s_tdata[3:0], s_tdata[5:4],
					s_tdata[29:6]));
			// accepted result
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_status.size() == 0) begin
					fail_count++;
					if (report_count < REPORT_MAX) begin
						report_count++;
						$display("unexpected result relays=%h drives=%h positions=%h",
							got.relays, got.drives, got.positions);
					end
				end else begin
					want = expected_status.pop_front();
					if (got.relays !== want.relays || got.drives !== want.drives ||
							got.positions !== want.positions) begin
						fail_count++;
						if (report_count < REPORT_MAX) begin
							report_count++;
							$display("mismatch relays exp %h got %h, %s %h got %h, %s %h got %h",
								want.relays, got.relays, "drives exp", want.drives,
								got.drives, "positions exp", want.positions,
								got.positions);
						end
					end
				end
			end
			pending = expected_status.size();
		end
	end

endmodule

// ===== tb/tb_window_blind_relay_controller_unit.sv =====
// stimulus and verdict for the window blind relay controller
`timescale 1ns / 1ps

module tb_window_blind_relay_controller_unit;
	import wbrc_pkg::*;

	localparam logic [3:0]  OP_UNUSED_LO = 4'd9;
	localparam logic [3:0]  OP_UNUSED_HI = 4'd15;
	localparam logic [23:0] TICKS_MAX    = 24'hFFFFFF;
	localparam logic [23:0] STEP_MAX     = 24'h00FFFF;
	localparam int          HOLD_CYCLES  = 80;
	localparam int          CYCLE_LIMIT  = 300000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // op [3:0], channel [5:4], run_time [29:6]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // relay_outputs [7:0], drive_states [15:8], positions [23:16]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int hold_requests = 0;
	int holds_done = 0;

	always #5 clk = ~clk;

	window_blind_relay_controller_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wbrc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: long hold on demand, otherwise a rotating stall pattern
	initial begin
		int beat;
		int mode;
		beat = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				mode = (beat / 64) % 3;
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= (beat % 4 == 0);
				endcase
				beat++;
			end
		end
	end

	function automatic logic [31:0] pack_req(logic [3:0] op, logic [1:0] ch,
			logic [23:0] run_time);
		return {2'b00, run_time, ch, op};
	endfunction

	// random request, ticks common so that runs expire often
	function automatic logic [31:0] random_req();
		logic [3:0]  op;
		logic [23:0] run_time;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			op = OP_TICK;
		else if (pick < 50)
			op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		else
			op = 4'($urandom_range(OP_UP, OP_STOP));
		if ($urandom_range(0, 4) == 0)
			run_time = 24'($urandom());
		else
			run_time = 24'($urandom_range(0, 24));
		return pack_req(op, 2'($urandom_range(0, 3)), run_time);
	endfunction

	// offer one request and hold it until taken; returns at a falling edge
	task automatic send_req(input logic [31:0] req);
		s_tvalid <= 1'b1;
		s_tdata  <= req;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [23:0] full, input logic [23:0] gap,
			input logic [23:0] step);
		write_reg(CFG_FULL_TRAVEL, full);
		write_reg(CFG_SUN_GAP, gap);
		write_reg(CFG_STAGGER_STEP, step);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// bursts of random length with random gaps, sometimes none
	task automatic random_traffic(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 16);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_req(random_req());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 6));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default timing: starts, repeats, opposites, toggles, sun, stop, unused ops
		send_req(pack_req(OP_UP, 2'd0, '0));
		send_req(pack_req(OP_UP, 2'd0, '0));
		send_req(pack_req(OP_DOWN, 2'd0, TICKS_MAX));
		send_req(pack_req(OP_TOGGLE_UP, 2'd1, '0));
		send_req(pack_req(OP_TOGGLE_UP, 2'd1, '0));
		send_req(pack_req(OP_TOGGLE_DN, 2'd2, '0));
		send_req(pack_req(OP_SUN, 2'd3, '0));
		send_req(pack_req(OP_UP_TIMED, 2'd1, '0));
		send_req(pack_req(OP_TICK, 2'd3, TICKS_MAX));
		send_req(pack_req(OP_DOWN_TIMED, 2'd2, TICKS_MAX));
		send_req(pack_req(OP_UNUSED_LO, 2'd3, TICKS_MAX));
		send_req(pack_req(OP_UNUSED_HI, 2'd0, '0));
		send_req(pack_req(OP_STOP, 2'd3, '0));
		drain();

		// shortest timing: runs reach the end, sun closes then opens a zero gap
		set_timing(24'd1, '0, '0);
		send_req(pack_req(OP_DOWN, 2'd0, '0));
		send_req(pack_req(OP_TICK, 2'd0, '0));
		send_req(pack_req(OP_DOWN, 2'd0, '0));
		send_req(pack_req(OP_SUN, 2'd0, '0));
		send_req(pack_req(OP_TICK, 2'd0, '0));
		send_req(pack_req(OP_SUN, 2'd1, '0));
		send_req(pack_req(OP_TICK, 2'd0, '0));
		send_req(pack_req(OP_TICK, 2'd0, '0));
		send_req(pack_req(OP_UP_TIMED, 2'd2, 24'd1));
		send_req(pack_req(OP_TICK, 2'd0, '0));
		send_req(pack_req(OP_UP, 2'd2, '0));
		send_req(pack_req(OP_STOP, 2'd2, '0));
		drain();

		// longest timing and widest stagger
		set_timing(TICKS_MAX, TICKS_MAX, STEP_MAX);
		random_traffic(50);
		drain();

		set_timing(24'd1, '0, '0);
		random_traffic(120);
		drain();

		// result side held off while requests keep coming
		set_timing(24'($urandom_range(2, 10)), 24'($urandom_range(1, 6)),
			24'($urandom_range(0, 3)));
		hold_requests++;
		random_traffic(120);
		drain();

		// pause halfway until every result is back
		set_timing(24'($urandom_range(2, 10)), 24'($urandom_range(0, 6)),
			24'($urandom_range(0, 3)));
		random_traffic(60);
		drain();
		random_traffic(60);
		drain();

		set_timing(24'd4, 24'd3, 24'd2);
		random_traffic(120);
		drain();

		set_timing(24'($urandom_range(1, 12)), 24'($urandom_range(0, 8)),
			24'($urandom_range(0, 4)));
		random_traffic(120);
		drain();

		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/wbrc_pkg.sv
design/wbrc_cell.sv
design/window_blind_relay_controller_unit.sv
tb/wbrc_checker.sv
tb/tb_window_blind_relay_controller_unit.sv
